>>> design/lpd_pkg.sv
// Shared constants and types of the packet point decoder.
`default_nettype none

package lpd_pkg;

	localparam int ANGLE_BINS        = 400;
	localparam int PAYLOAD_BYTES     = 56;
	localparam int POINTS_PER_PACKET = 16;

	localparam int BYTE_W  = 8;
	localparam int ANGLE_W = 9;
	localparam int RANGE_W = 14;
	localparam int RAW_W   = 15;
	localparam int BIN_W   = $clog2(ANGLE_BINS + 1);
	localparam int PT_W    = $clog2(POINTS_PER_PACKET);

	localparam int CNT_W     = $clog2(PAYLOAD_BYTES);
	localparam int RAM_AW    = CNT_W + 1;
	localparam int RAM_DEPTH = 2 ** RAM_AW;

	localparam logic [BYTE_W-1:0] SYNC_0 = 8'h55;
	localparam logic [BYTE_W-1:0] SYNC_1 = 8'haa;
	localparam logic [BYTE_W-1:0] SYNC_2 = 8'h23;
	localparam logic [BYTE_W-1:0] SYNC_3 = 8'h10;

	localparam logic [CNT_W-1:0] IDX_START_LO  = CNT_W'(2);
	localparam logic [CNT_W-1:0] IDX_START_HI  = CNT_W'(3);
	localparam logic [CNT_W-1:0] IDX_END_LO    = CNT_W'(52);
	localparam logic [CNT_W-1:0] IDX_END_HI    = CNT_W'(53);
	localparam logic [CNT_W-1:0] IDX_LAST      = CNT_W'(PAYLOAD_BYTES - 1);
	localparam logic [CNT_W-1:0] FIRST_SAMPLE  = CNT_W'(4);
	localparam logic [CNT_W-1:0] SAMPLE_STRIDE = CNT_W'(3);

	localparam int ANG_W       = 17;
	localparam int M_W         = 21;
	localparam int ANGLE_OFFSET = 'h2000;
	localparam int FULL_TURN   = 23040;
	localparam int ANGLE_DEN   = 368640;
	localparam int DEN_SHIFT   = 13;
	localparam int DEN_ODD     = ANGLE_DEN >> DEN_SHIFT;
	localparam int DEN_HALF    = ANGLE_DEN / 2;
	localparam int RECIP_SH    = 25;
	localparam int RECIP       = (2 ** RECIP_SH + DEN_ODD - 1) / DEN_ODD;
	localparam int RECIP_W     = $clog2(RECIP + 1);

	localparam int PROD_W = M_W + BIN_W + 1;
	localparam int T_W    = PROD_W - DEN_SHIFT;
	localparam int QUO_W  = BIN_W + 2;
	localparam int QS_W   = BIN_W + 3;

	localparam logic signed [BIN_W:0]   BINS_S  = (BIN_W + 1)'(ANGLE_BINS);
	localparam logic [RECIP_W-1:0]      RECIP_V = RECIP_W'(RECIP);

	typedef struct packed {
		logic [RAW_W-1:0] start_raw;
		logic [RAW_W-1:0] end_raw;
	} desc_t;

	typedef struct packed {
		logic              en;
		logic [RAM_AW-1:0] addr;
		logic [BYTE_W-1:0] data;
	} ram_wr_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic wr_bank;
		logic rd_bank;
	} q_stat_t;

endpackage

`default_nettype wire

>>> design/lpd_ram.sv
// Generic single write port RAM with registered read.
`default_nettype none

module lpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> design/lpd_front.sv
// Sync hunt and payload collection into the packet buffer.
`default_nettype none

module lpd_front (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     push,
	input  wire logic [lpd_pkg::BYTE_W-1:0] data_byte,
	output logic                          full,
	input  wire lpd_pkg::q_stat_t         q_stat,
	output lpd_pkg::ram_wr_t              ram_wr,
	output logic                          q_push,
	output lpd_pkg::desc_t                q_desc
);
	import lpd_pkg::*;

	localparam logic [2:0] PH_HUNT = 3'd0;
	localparam logic [2:0] PH_AA   = 3'd1;
	localparam logic [2:0] PH_23   = 3'd2;
	localparam logic [2:0] PH_10   = 3'd3;
	localparam logic [2:0] PH_DATA = 3'd4;

	logic [2:0]       phase_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       st_lo_q;
	logic [6:0]       st_hi_q;
	logic [7:0]       en_lo_q;
	logic [6:0]       en_hi_q;
	logic             acc;

	assign full = (phase_q == PH_DATA) && q_stat.full;
	assign acc  = push && !full;

	assign ram_wr.en   = acc && (phase_q == PH_DATA);
	assign ram_wr.addr = {q_stat.wr_bank, cnt_q};
	assign ram_wr.data = data_byte;

	assign q_push           = ram_wr.en && (cnt_q == IDX_LAST);
	assign q_desc.start_raw = {st_hi_q, st_lo_q};
	assign q_desc.end_raw   = {en_hi_q, en_lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			cnt_q   <= '0;
		end else if (acc) begin
			case (phase_q)
				PH_AA:   phase_q <= (data_byte == SYNC_1) ? PH_23 : PH_HUNT;
				PH_23:   phase_q <= (data_byte == SYNC_2) ? PH_10 : PH_HUNT;
				PH_10:   phase_q <= (data_byte == SYNC_3) ? PH_DATA : PH_HUNT;
				PH_DATA: begin
					if (cnt_q == IDX_LAST) begin
						cnt_q   <= '0;
						phase_q <= PH_HUNT;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				default: phase_q <= (data_byte == SYNC_0) ? PH_AA : PH_HUNT;
			endcase
		end
	end

	// capture the angle bytes as they pass
	always_ff @(posedge clk) begin
		if (ram_wr.en) begin
			case (cnt_q)
				IDX_START_LO: st_lo_q <= data_byte;
				IDX_START_HI: st_hi_q <= data_byte[6:0];
				IDX_END_LO:   en_lo_q <= data_byte;
				IDX_END_HI:   en_hi_q <= data_byte[6:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> design/lpd_pkt_queue.sv
// Two-entry queue of packet descriptors, one per buffer bank.
`default_nettype none

module lpd_pkt_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire lpd_pkg::desc_t   desc_in,
	input  wire logic             pop,
	output lpd_pkg::desc_t        head,
	output lpd_pkg::q_stat_t      stat
);
	import lpd_pkg::*;

	desc_t      ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign head         = ent_q[rd_ptr_q];
	assign stat.full    = (cnt_q == 2'd2);
	assign stat.empty   = (cnt_q == 2'd0);
	assign stat.wr_bank = wr_ptr_q;
	assign stat.rd_bank = rd_ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= desc_in;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full || pop)
		else $error("descriptor pushed into a full queue");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("descriptor count out of range");

endmodule

`default_nettype wire

>>> design/lpd_back.sv
// Point decode sequencer and output register.
`default_nettype none

module lpd_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire lpd_pkg::q_stat_t            q_stat,
	input  wire lpd_pkg::desc_t              head,
	output logic                             q_pop,
	output logic [lpd_pkg::RAM_AW-1:0]       raddr,
	input  wire logic [lpd_pkg::BYTE_W-1:0]  rdata,
	output logic                             empty,
	input  wire logic                        pop,
	output logic [lpd_pkg::ANGLE_W-1:0]      angle_bin,
	output logic [lpd_pkg::RANGE_W-1:0]      range_mm,
	output logic [lpd_pkg::BYTE_W-1:0]       intensity,
	output logic                             last_of_packet,
	output logic                             scan_complete
);
	import lpd_pkg::*;

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_RD   = 3'd1;
	localparam logic [2:0] B_DIV  = 3'd2;
	localparam logic [2:0] B_REC  = 3'd3;
	localparam logic [2:0] B_EMIT = 3'd4;

	localparam logic [PT_W-1:0] LAST_PT = PT_W'(POINTS_PER_PACKET - 1);

	logic [2:0]              st_q;
	logic [1:0]              k_q;
	logic [PT_W-1:0]         pt_q;
	logic [CNT_W-1:0]        byte_q;
	logic signed [M_W-1:0]   m_q;
	logic signed [ANG_W-1:0] d_q;
	logic                    wrap_q;
	logic signed [PROD_W-1:0] prod_q;
	logic                    neg_q;
	logic [T_W-1:0]          t_q;
	logic [QUO_W-1:0]        quo_q;
	logic [BYTE_W-1:0]       b0_q, b1_q, b2_q;
	logic                    out_valid_q;

	logic signed [ANG_W-1:0] s_val, e_val, diff, d_val;
	logic                    wrapped;
	logic signed [M_W-1:0]   m_init;
	logic [PROD_W-1:0]       mag, mag_rnd;
	logic [T_W+RECIP_W-1:0]  rec_prod;
	logic signed [QS_W-1:0]  qmag, qs, v1, v2;
	logic [BIN_W-1:0]        idx, abin;
	logic                    out_free, out_load;

	always_comb begin
		s_val   = ANG_W'({2'b00, head.start_raw}) - ANG_W'(ANGLE_OFFSET);
		e_val   = ANG_W'({2'b00, head.end_raw}) - ANG_W'(ANGLE_OFFSET);
		wrapped = e_val < s_val;
		diff    = e_val - s_val;
		d_val   = wrapped ? diff + ANG_W'(FULL_TURN) : diff;
		m_init  = M_W'(s_val) <<< 4;
	end

	always_comb begin
		mag      = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
		mag_rnd  = mag + PROD_W'(DEN_HALF);
		rec_prod = t_q * RECIP_V;
	end

	// true modulo of the signed bin index, then mirror
	always_comb begin
		qmag = QS_W'(quo_q);
		qs   = neg_q ? -qmag : qmag;
		v1   = qs[QS_W-1] ? qs + QS_W'(ANGLE_BINS) : qs;
		if (v1 >= QS_W'(2 * ANGLE_BINS)) begin
			v2 = v1 - QS_W'(2 * ANGLE_BINS);
		end else if (v1 >= QS_W'(ANGLE_BINS)) begin
			v2 = v1 - QS_W'(ANGLE_BINS);
		end else begin
			v2 = v1;
		end
		idx  = BIN_W'(v2);
		abin = BIN_W'(ANGLE_BINS - 1) - idx;
	end

	assign out_free = !out_valid_q || pop;
	assign out_load = (st_q == B_EMIT) && out_free;
	assign q_pop    = out_load && (pt_q == LAST_PT);
	assign raddr    = {q_stat.rd_bank, byte_q + CNT_W'(k_q)};
	assign empty    = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= B_IDLE;
			k_q         <= '0;
			pt_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				B_IDLE: begin
					if (!q_stat.empty) begin
						st_q <= B_RD;
						k_q  <= '0;
						pt_q <= '0;
					end
				end
				B_RD: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						st_q <= B_DIV;
					end
				end
				B_DIV: st_q <= B_REC;
				B_REC: st_q <= B_EMIT;
				B_EMIT: begin
					if (out_free) begin
						pt_q <= pt_q + PT_W'(1);
						k_q  <= '0;
						st_q <= (pt_q == LAST_PT) ? B_IDLE : B_RD;
					end
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			B_IDLE: begin
				m_q    <= m_init;
				d_q    <= d_val;
				wrap_q <= wrapped;
				byte_q <= FIRST_SAMPLE;
			end
			B_RD: begin
				if (k_q == 2'd0) begin
					prod_q <= m_q * BINS_S;
				end
				if (k_q == 2'd1) begin
					b0_q <= rdata;
				end
				if (k_q == 2'd2) begin
					b1_q <= rdata;
				end
				if (k_q == 2'd3) begin
					b2_q <= rdata;
				end
			end
			B_DIV: begin
				neg_q <= prod_q[PROD_W-1];
				t_q   <= T_W'(mag_rnd >> DEN_SHIFT);
			end
			B_REC: quo_q <= QUO_W'(rec_prod >> RECIP_SH);
			B_EMIT: begin
				if (out_free) begin
					m_q    <= m_q + M_W'(d_q);
					byte_q <= byte_q + SAMPLE_STRIDE;
				end
			end
			default: ;
		endcase
		if (out_load) begin
			angle_bin      <= ANGLE_W'(abin);
			range_mm       <= {b1_q[5:0], b0_q};
			intensity      <= b2_q;
			last_of_packet <= (pt_q == LAST_PT);
			scan_complete  <= (pt_q == LAST_PT) && wrap_q;
		end
	end

	a_pop_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty && (pt_q == LAST_PT))
		else $error("packet released before its last point");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pop) |-> !out_load)
		else $error("pending point overwritten");

endmodule

`default_nettype wire

>>> design/lidar_packet_point_decoder_top.sv
// Top level of the packet point decoder.
// Throughput: one byte per cycle; payload bytes stall only while both packet buffers are held.
// Decode: for each point of a packet the sequencer does three buffer reads, multiply, round,
// reciprocal and emit; emit waits while the output register holds an unpopped point.
// Reset: arst_n clears the sync hunt, counters, queue and output valid at once;
// the packet buffer RAM is not cleared and needs no sweep.
`default_nettype none

module lidar_packet_point_decoder_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	output logic                             full,
	input  wire logic [lpd_pkg::BYTE_W-1:0]  data_byte,
	output logic                             empty,
	input  wire logic                        pop,
	output logic [lpd_pkg::ANGLE_W-1:0]      angle_bin,
	output logic [lpd_pkg::RANGE_W-1:0]      range_mm,
	output logic [lpd_pkg::BYTE_W-1:0]       intensity,
	output logic                             last_of_packet,
	output logic                             scan_complete
);
	import lpd_pkg::*;

	q_stat_t           q_stat;
	ram_wr_t           ram_wr;
	desc_t             q_desc;
	desc_t             head;
	logic              q_push;
	logic              q_pop;
	logic [RAM_AW-1:0] raddr;
	logic [BYTE_W-1:0] rdata;

	lpd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.data_byte (data_byte),
		.full      (full),
		.q_stat    (q_stat),
		.ram_wr    (ram_wr),
		.q_push    (q_push),
		.q_desc    (q_desc)
	);

	lpd_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_wr.en),
		.waddr (ram_wr.addr),
		.wdata (ram_wr.data),
		.raddr (raddr),
		.rdata (rdata)
	);

	lpd_pkt_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.desc_in (q_desc),
		.pop     (q_pop),
		.head    (head),
		.stat    (q_stat)
	);

	lpd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_stat         (q_stat),
		.head           (head),
		.q_pop          (q_pop),
		.raddr          (raddr),
		.rdata          (rdata),
		.empty          (empty),
		.pop            (pop),
		.angle_bin      (angle_bin),
		.range_mm       (range_mm),
		.intensity      (intensity),
		.last_of_packet (last_of_packet),
		.scan_complete  (scan_complete)
	);

endmodule

`default_nettype wire
